### hdl/send_window_sequence_control_assert.svh
// assertion macros for the send window sequence control block
`ifndef SEND_WINDOW_SEQUENCE_CONTROL_ASSERT_SVH
`define SEND_WINDOW_SEQUENCE_CONTROL_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SWSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SWSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/swsc_pkg.sv
// types and constants shared by the send window sequence control block
`timescale 1ns / 1ps

package swsc_pkg;

  localparam int unsigned SeqBitsDef   = 3;
  localparam int unsigned PeerCountDef = 4;

  typedef enum logic [2:0] {
    CmdConfirm = 3'd0,
    CmdEnqueue = 3'd1,
    CmdAdvance = 3'd2,
    CmdRewind  = 3'd3,
    CmdReset   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] peer;
    logic [2:0] ack_seq;
    logic       slot_free;
  } req_t;

  typedef struct packed {
    logic [2:0] confirmed_seq;
    logic       confirmed_valid;
    logic       last_result;
    logic       out_of_sync;
    logic       accepted;
    logic [2:0] frame_seq;
    logic [2:0] send_seq;
    logic       window_open;
    logic       all_sent;
    logic       has_unconfirmed;
  } rsp_t;

endpackage

### hdl/send_window_sequence_control.sv
// per-peer go-back-n transmit window with one shared sequence incrementer
//
// input channel: in_valid_i / in_stall_o carry one request (command, peer,
// ack number, slot free). the block takes a request only when idle and
// raises in_stall_o until the last result of that request has been taken.
// output channel: out_valid_o / out_stall_i carry results from an output
// register. confirm gives one result per confirmed frame (at most
// 2^SEQ_BITS-1) or a single one if none is confirmed; every other
// command gives exactly one; last_result marks the final one.
// timing: each result passes the shared incrementer twice (state update,
// then status). a stall holds the result register and the sequencer in
// place; nothing is lost or repeated.
// reset: every peer's oldest-unconfirmed, queue-end and send numbers clear
// to zero at once, and the block comes out of reset ready.
`timescale 1ns / 1ps
`include "send_window_sequence_control_assert.svh"

module send_window_sequence_control #(
  parameter int unsigned SEQ_BITS   = swsc_pkg::SeqBitsDef,
  parameter int unsigned PEER_COUNT = swsc_pkg::PeerCountDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  swsc_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output swsc_pkg::rsp_t  out_rsp_o
);

  import swsc_pkg::*;

  localparam int unsigned SeqW  = SEQ_BITS;
  localparam int unsigned PeerW = (PEER_COUNT > 1) ? $clog2(PEER_COUNT) : 1;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StStat,
    StOut
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  logic [SeqW-1:0] oldest_q [PEER_COUNT];
  logic [SeqW-1:0] qend_q   [PEER_COUNT];
  logic [SeqW-1:0] sendp_q  [PEER_COUNT];

  // request and working copy of the selected peer
  cmd_e             cmd_q;
  logic [PeerW-1:0] peer_q;
  logic [SeqW-1:0]  ack_q;
  logic             room_q;
  logic             bad_q;
  logic [SeqW-1:0]  o_q;
  logic [SeqW-1:0]  q_q;
  logic [SeqW-1:0]  s_q;

  // result of the current step
  logic [SeqW-1:0]  cseq_q;
  logic             cvalid_q;
  logic             last_q;
  logic             oos_q;
  logic             acc_q;
  logic [SeqW-1:0]  fseq_q;

  rsp_t             rsp_q;

  logic             in_acc;
  logic             out_acc;
  logic             in_bad;
  logic [PeerW-1:0] in_idx;
  logic [SeqW-1:0]  unit_a;
  logic [SeqW-1:0]  unit_b;
  logic [SeqW-1:0]  unit_sum;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;
  assign out_acc     = out_valid_q && !out_stall_i;

  assign in_bad = (32'(in_req_i.peer) >= PEER_COUNT);
  assign in_idx = PeerW'(in_req_i.peer);

  // shared incrementer: +1, or -1 for rewind; status pass uses queue end
  always_comb begin
    unit_a = '0;
    unit_b = SeqW'(1);
    if (state_q == StStat) begin
      unit_a = q_q;
    end else begin
      case (cmd_q)
        CmdConfirm: unit_a = o_q;
        CmdEnqueue: unit_a = q_q;
        CmdAdvance: unit_a = s_q;
        CmdRewind: begin
          unit_a = s_q;
          unit_b = '1;
        end
        default: unit_a = '0;
      endcase
    end
  end

  assign unit_sum = unit_a + unit_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            state_q <= StExec;
          end
        end
        StExec: state_q <= StStat;
        StStat: begin
          out_valid_q <= 1'b1;
          state_q     <= StOut;
        end
        StOut: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
            state_q     <= rsp_q.last_result ? StIdle : StExec;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= cmd_e'(in_req_i.command);
      peer_q <= in_idx;
      ack_q  <= SeqW'(in_req_i.ack_seq);
      room_q <= in_req_i.slot_free;
      bad_q  <= in_bad;
      o_q    <= in_bad ? '0 : oldest_q[in_idx];
      q_q    <= in_bad ? '0 : qend_q[in_idx];
      s_q    <= in_bad ? '0 : sendp_q[in_idx];
    end

    if (state_q == StExec) begin
      cseq_q   <= '0;
      cvalid_q <= 1'b0;
      last_q   <= 1'b1;
      oos_q    <= 1'b0;
      acc_q    <= 1'b0;
      fseq_q   <= '0;
      if (!bad_q) begin
        case (cmd_q)
          CmdConfirm: begin
            if (ack_q == o_q) begin
              last_q <= 1'b1;
            end else if (o_q == q_q) begin
              // ack beyond the queued frames
              oos_q <= 1'b1;
            end else begin
              o_q      <= unit_sum;
              cseq_q   <= o_q;
              cvalid_q <= 1'b1;
              // the walk ends at the ack or runs into the queue end
              last_q   <= (unit_sum == ack_q) || (unit_sum == q_q);
              oos_q    <= (unit_sum != ack_q) && (unit_sum == q_q);
            end
          end
          CmdEnqueue: begin
            if (room_q) begin
              q_q    <= unit_sum;
              acc_q  <= 1'b1;
              fseq_q <= q_q;
            end
          end
          CmdAdvance: s_q <= unit_sum;
          CmdRewind:  s_q <= unit_sum;
          CmdReset: begin
            o_q <= '0;
            q_q <= '0;
            s_q <= '0;
          end
          default: s_q <= s_q;
        endcase
      end
    end

    if (state_q == StStat) begin
      rsp_q.confirmed_seq   <= 3'(cseq_q);
      rsp_q.confirmed_valid <= cvalid_q;
      rsp_q.last_result     <= last_q;
      rsp_q.out_of_sync     <= oos_q;
      rsp_q.accepted        <= acc_q;
      rsp_q.frame_seq       <= 3'(fseq_q);
      rsp_q.send_seq        <= bad_q ? 3'd0 : 3'(s_q);
      rsp_q.window_open     <= !bad_q && (unit_sum != o_q);
      rsp_q.all_sent        <= !bad_q && (s_q == q_q);
      rsp_q.has_unconfirmed <= !bad_q && (o_q != q_q);
    end
  end

  // per-peer window numbers, written back once per result for a peer in range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PEER_COUNT; i++) begin
        oldest_q[i] <= '0;
        qend_q[i]   <= '0;
        sendp_q[i]  <= '0;
      end
    end else if (state_q == StStat && !bad_q) begin
      oldest_q[peer_q] <= o_q;
      qend_q[peer_q]   <= q_q;
      sendp_q[peer_q]  <= s_q;
    end
  end

  `SWSC_ASSERT_NOW(a_ready_no_result, !in_stall_o, !out_valid_o, "ready while a result waits")
  `SWSC_ASSERT_NOW(a_more_is_confirm, out_valid_o && !out_rsp_o.last_result,
                   out_rsp_o.confirmed_valid, "non-final result without a confirmed frame")
  `SWSC_ASSERT_NOW(a_oos_on_last, out_valid_o && out_rsp_o.out_of_sync,
                   out_rsp_o.last_result, "out of sync flagged before the final result")
  `SWSC_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o,
                    "request taken but block still ready")
  `SWSC_ASSERT_NEXT(a_ready_after_last, out_valid_o && !out_stall_i && out_rsp_o.last_result,
                    !in_stall_o, "block not ready after the final result")

endmodule

### bench/tb_send_window_sequence_control.sv
// self-checking testbench for the per-peer send window sequence control block
`timescale 1ns / 1ps

module tb_send_window_sequence_control;
  import swsc_pkg::*;

  // command codes the block does not define
  localparam logic [2:0] CmdSpare5 = 3'd5;
  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;
  localparam int unsigned RandomRequests = 400;

  // field order: confirmed_seq, confirmed_valid, last_result, out_of_sync, accepted,
  // frame_seq, send_seq, window_open, all_sent, has_unconfirmed
  localparam rsp_t EmptyPeer  = {3'd0, 1'b0, 1'b1, 1'b0, 1'b0, 3'd0, 3'd0, 1'b1, 1'b1, 1'b0};
  localparam rsp_t EmptyOos   = {3'd0, 1'b0, 1'b1, 1'b1, 1'b0, 3'd0, 3'd0, 1'b1, 1'b1, 1'b0};
  localparam rsp_t FirstFrame = {3'd0, 1'b0, 1'b1, 1'b0, 1'b1, 3'd0, 3'd0, 1'b1, 1'b0, 1'b1};
  localparam rsp_t WrapBack   = {3'd0, 1'b0, 1'b1, 1'b0, 1'b0, 3'd0, 3'd7, 1'b1, 1'b0, 1'b0};

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } row_t;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_req_i    = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  bit   calm = 1'b0;
  int   mismatches = 0;
  rsp_t expected_rsp_q[$];
  row_t plan_q[$];

  logic [SeqBitsDef-1:0] oldest_seq    [PeerCountDef];
  logic [SeqBitsDef-1:0] queue_end_seq [PeerCountDef];
  logic [SeqBitsDef-1:0] send_ptr_seq  [PeerCountDef];

  send_window_sequence_control DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_req_i,
    .out_valid_o,
    .out_stall_i,
    .out_rsp_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic rsp_t window_status(input logic [1:0] p);
    rsp_t s;
    logic [2:0] nxt;
    s = '0;
    nxt = queue_end_seq[p] + 3'd1;
    s.send_seq        = send_ptr_seq[p];
    s.window_open     = (nxt != oldest_seq[p]);
    s.all_sent        = (send_ptr_seq[p] == queue_end_seq[p]);
    s.has_unconfirmed = (oldest_seq[p] != queue_end_seq[p]);
    return s;
  endfunction

  // updates the window copy and queues every result one request causes
  function automatic void predict_results(input req_t r);
    logic [1:0] p;
    logic [2:0] cur;
    rsp_t e;
    bit stuck;
    int n;
    p = r.peer;
    cur = '0;
    stuck = 1'b0;
    n = 0;
    case (r.command)
      CmdConfirm: begin
        while (r.ack_seq != oldest_seq[p] && !stuck) begin
          cur = oldest_seq[p];
          if (cur == queue_end_seq[p]) begin
            stuck = 1'b1;
          end else begin
            oldest_seq[p] = cur + 3'd1;
            e = window_status(p);
            e.confirmed_seq = cur;
            e.confirmed_valid = 1'b1;
            expected_rsp_q.push_back(e);
            n++;
          end
        end
        if (n == 0) e = window_status(p);
        else e = expected_rsp_q.pop_back();
        e.last_result = 1'b1;
        e.out_of_sync = stuck;
        expected_rsp_q.push_back(e);
      end
      CmdEnqueue: begin
        // only the frame store's room counts, never the window
        if (r.slot_free) begin
          cur = queue_end_seq[p];
          queue_end_seq[p] = cur + 3'd1;
        end
      end
      CmdAdvance: send_ptr_seq[p] = send_ptr_seq[p] + 3'd1;
      CmdRewind:  send_ptr_seq[p] = send_ptr_seq[p] - 3'd1;
      CmdReset: begin
        oldest_seq[p] = '0;
        queue_end_seq[p] = '0;
        send_ptr_seq[p] = '0;
      end
      default: ;
    endcase
    if (r.command != CmdConfirm) begin
      e = window_status(p);
      e.last_result = 1'b1;
      if (r.command == CmdEnqueue && r.slot_free) begin
        e.accepted = 1'b1;
        e.frame_seq = cur;
      end
      expected_rsp_q.push_back(e);
    end
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic add_row(input logic [2:0] cmd, input logic [1:0] p, input logic [2:0] ack,
                         input logic sf, input bit typed, input rsp_t rsp);
    row_t row;
    row.req = {cmd, p, ack, sf};
    row.typed = typed;
    row.rsp = rsp;
    plan_q.push_back(row);
  endtask

  task automatic pace_sender();
    if (!calm && $urandom_range(0, 99) < 13) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // called at a rising edge; returns at the edge where the request is taken
  task automatic issue_request(input req_t r);
    in_valid_i <= 1'b1;
    in_req_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_results(r);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 13);
  end

  always @(posedge clk_i) begin : watch_results
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsp_q.size() == 0) begin
        $error("result with nothing expected: %h", out_rsp_o);
        mismatches++;
      end else begin
        want = expected_rsp_q.pop_front();
        check_field("confirmed_seq", want.confirmed_seq, out_rsp_o.confirmed_seq);
        check_field("confirmed_valid", want.confirmed_valid, out_rsp_o.confirmed_valid);
        check_field("last_result", want.last_result, out_rsp_o.last_result);
        check_field("out_of_sync", want.out_of_sync, out_rsp_o.out_of_sync);
        check_field("accepted", want.accepted, out_rsp_o.accepted);
        check_field("frame_seq", want.frame_seq, out_rsp_o.frame_seq);
        check_field("send_seq", want.send_seq, out_rsp_o.send_seq);
        check_field("window_open", want.window_open, out_rsp_o.window_open);
        check_field("all_sent", want.all_sent, out_rsp_o.all_sent);
        check_field("has_unconfirmed", want.has_unconfirmed, out_rsp_o.has_unconfirmed);
      end
    end
  end

  initial begin
    req_t r;
    logic [1:0] p;
    logic [2:0] span;
    int dice;
    foreach (oldest_seq[i]) begin
      oldest_seq[i] = '0;
      queue_end_seq[i] = '0;
      send_ptr_seq[i] = '0;
    end

    // nothing to confirm, then empty queue with a foreign ack number
    add_row(CmdConfirm, 2'd0, 3'd0, 1'b0, 1'b1, EmptyPeer);
    add_row(CmdConfirm, 2'd1, 3'd5, 1'b1, 1'b1, EmptyOos);
    add_row(CmdEnqueue, 2'd0, 3'd7, 1'b0, 1'b1, EmptyPeer);
    add_row(CmdEnqueue, 2'd0, 3'd0, 1'b1, 1'b1, FirstFrame);
    for (int i = 0; i < 6; i++) add_row(CmdEnqueue, 2'd0, 3'(i), 1'b1, 1'b0, '0);
    // window is full now; no room in the store either
    add_row(CmdEnqueue, 2'd0, 3'd3, 1'b0, 1'b0, '0);
    add_row(CmdAdvance, 2'd0, 3'd0, 1'b0, 1'b0, '0);
    add_row(CmdAdvance, 2'd0, 3'd7, 1'b1, 1'b0, '0);
    add_row(CmdRewind,  2'd0, 3'd2, 1'b0, 1'b0, '0);
    // confirms the whole window, seven results
    add_row(CmdConfirm, 2'd0, 3'd7, 1'b0, 1'b0, '0);
    add_row(CmdEnqueue, 2'd2, 3'd0, 1'b1, 1'b0, '0);
    add_row(CmdEnqueue, 2'd2, 3'd0, 1'b1, 1'b0, '0);
    // ack lies past the queue end: two frames confirmed, then out of sync
    add_row(CmdConfirm, 2'd2, 3'd5, 1'b0, 1'b0, '0);
    add_row(CmdRewind,  2'd3, 3'd0, 1'b0, 1'b1, WrapBack);
    add_row(CmdSpare5,  2'd1, 3'd7, 1'b1, 1'b0, '0);
    add_row(CmdSpare6,  2'd2, 3'd1, 1'b0, 1'b0, '0);
    add_row(CmdSpare7,  2'd3, 3'd7, 1'b1, 1'b0, '0);
    add_row(CmdReset,   2'd0, 3'd4, 1'b1, 1'b1, EmptyPeer);
    // full window with room in the store: queue end wraps onto the oldest
    for (int i = 0; i < 8; i++) add_row(CmdEnqueue, 2'd1, 3'd0, 1'b1, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      pace_sender();
      issue_request(plan_q[i].req);
      if (plan_q[i].typed) begin
        void'(expected_rsp_q.pop_back());
        expected_rsp_q.push_back(plan_q[i].rsp);
      end
    end

    for (int idx = 0; idx < RandomRequests; idx++) begin
      calm = (idx >= 120 && idx < 220);
      p = 2'($urandom_range(0, PeerCountDef - 1));
      r.peer = p;
      r.ack_seq = 3'($urandom_range(0, 7));
      r.slot_free = 1'($urandom_range(0, 1));
      dice = $urandom_range(0, 99);
      if (dice < 30) begin
        r.command = CmdEnqueue;
        r.slot_free = ($urandom_range(0, 9) != 0);
      end else if (dice < 50) begin
        // ack somewhere inside the outstanding frames
        r.command = CmdConfirm;
        span = queue_end_seq[p] - oldest_seq[p];
        r.ack_seq = oldest_seq[p] + 3'($urandom_range(0, span));
      end else if (dice < 58) begin
        r.command = CmdConfirm;
      end else if (dice < 70) begin
        r.command = CmdAdvance;
      end else if (dice < 78) begin
        r.command = CmdRewind;
      end else if (dice < 84) begin
        r.command = CmdReset;
      end else if (dice < 90) begin
        r.command = 3'($urandom_range(CmdSpare5, CmdSpare7));
      end else begin
        r = req_t'(9'($urandom));
      end
      if (idx == 300) begin
        // drain everything before going on
        in_valid_i <= 1'b0;
        wait (expected_rsp_q.size() == 0);
        @(posedge clk_i);
      end else begin
        pace_sender();
      end
      issue_request(r);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
